// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled away for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/sidc_pkg.sv =====
// ---------------------------------------------------------------------------
// sidc_pkg
// shared constants for the signed integer to decimal ascii converter
// ---------------------------------------------------------------------------
package sidc_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_BITS        = 32;
    localparam int CHAR_BITS      = 8;
    localparam int DIGIT_BITS     = 4;
    localparam int STAGE_STEPS    = 8;

    localparam int LOG10_2_NUM = 30103;
    localparam int LOG10_2_DEN = 100000;

    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = 8'd48;
    localparam logic [CHAR_BITS-1:0]  CHAR_MINUS    = 8'd45;
    localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ     = 4'd3;
    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX     = 4'd9;

    // decimal digits needed for the magnitude of the most negative value
    function automatic int num_digits(input int bits);
        return ((bits - 1) * LOG10_2_NUM) / LOG10_2_DEN + 1;
    endfunction

endpackage

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// converts a signed integer word into its decimal ascii text
// ---------------------------------------------------------------------------
// usage
//   s_* channel takes one signed integer word per handshake (s_tdata).
//   m_* channel gives the decimal text one character word per handshake,
//   most significant first, '-' ahead of negative values, m_tlast on the
//   final digit. zero gives a single '0'.
//   an accepted input word passes the magnitude stage, four
//   shift-and-add-3 stages of 8 bits each, the digit loader and the
//   output register before its first character leaves the block.
//   throughput: one character per cycle while m_tready is high, set by
//   the character serializer; one number gives 1 to 11 characters. the
//   conversion pipeline keeps taking input words until it fills.
//   reset clears all valid bits; no words are held afterwards.
//   when m_tready is low the output word holds and the pipeline backs up
//   stage by stage before s_tready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii
    import sidc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_BITS-1:0]   s_tdata,   // [31:0] value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAR_BITS-1:0] m_tdata,   // [7:0] character
    output logic                 m_tlast
);

    localparam int DIGITS     = num_digits(VALUE_BITS);
    localparam int BCD_BITS   = DIGITS * DIGIT_BITS;
    localparam int NUM_STAGES = (VALUE_BITS + STAGE_STEPS - 1) / STAGE_STEPS;
    localparam int LAST_STEPS = VALUE_BITS - STAGE_STEPS * (NUM_STAGES - 1);
    localparam int IDX_BITS   = $clog2(DIGITS);
    localparam logic [VALUE_BITS-1:0] ONE_V = VALUE_BITS'(1);

    logic [VALUE_BITS-1:0] value;
    logic                  value_neg;
    logic [VALUE_BITS-1:0] value_mag;

    logic                  stg_valid [0:NUM_STAGES];
    logic                  stg_ready [0:NUM_STAGES];
    logic [BCD_BITS-1:0]   stg_bcd   [0:NUM_STAGES];
    logic [VALUE_BITS-1:0] stg_bin   [0:NUM_STAGES];
    logic                  stg_neg   [0:NUM_STAGES];

    logic                  v0_reg;
    logic [VALUE_BITS-1:0] mag0_reg;
    logic                  neg0_reg;

    logic                  busy_reg,   busy_next;
    logic                  sign_reg,   sign_next;
    logic [IDX_BITS-1:0]   idx_reg,    idx_next;
    logic [BCD_BITS-1:0]   dig_reg;
    logic                  out_v_reg,  out_v_next;
    logic [CHAR_BITS-1:0]  char_reg,   char_next;
    logic                  last_reg,   last_next;

    logic                  emit;
    logic                  finishing;
    logic                  load_en;
    logic [IDX_BITS-1:0]   top_idx;
    logic [DIGIT_BITS-1:0] cur_digit;

    // magnitude stage
    assign value     = VALUE_BITS'(s_tdata);
    assign value_neg = value[VALUE_BITS-1];
    assign value_mag = value_neg ? (~value) + ONE_V : value;
    assign s_tready  = !v0_reg || stg_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mag0_reg <= value_mag;
            neg0_reg <= value_neg;
        end
    end

    assign stg_valid[0] = v0_reg;
    assign stg_bcd[0]   = '0;
    assign stg_bin[0]   = mag0_reg;
    assign stg_neg[0]   = neg0_reg;

    // bcd conversion stages
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_dabble
        sidc_dabble #(
            .VALUE_BITS (VALUE_BITS),
            .DIGITS     (DIGITS),
            .STEPS      ((g == NUM_STAGES - 1) ? LAST_STEPS : STAGE_STEPS)
        ) u_dabble (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_bcd    (stg_bcd[g]),
            .in_bin    (stg_bin[g]),
            .in_neg    (stg_neg[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_bcd   (stg_bcd[g+1]),
            .out_bin   (stg_bin[g+1]),
            .out_neg   (stg_neg[g+1])
        );
    end

    // character serializer
    assign emit      = busy_reg && (!out_v_reg || m_tready);
    assign finishing = emit && !sign_reg && (idx_reg == '0);
    assign load_en   = stg_valid[NUM_STAGES] && (!busy_reg || finishing);
    assign stg_ready[NUM_STAGES] = !busy_reg || finishing;
    assign cur_digit = dig_reg[idx_reg*DIGIT_BITS +: DIGIT_BITS];

    // highest nonzero digit
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (stg_bcd[NUM_STAGES][i*DIGIT_BITS +: DIGIT_BITS] != '0)
            begin
                top_idx = IDX_BITS'(i);
            end
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        sign_next  = sign_reg;
        idx_next   = idx_reg;
        out_v_next = out_v_reg && !m_tready;
        char_next  = char_reg;
        last_next  = last_reg;
        if (emit)
        begin
            out_v_next = 1'b1;
            if (sign_reg)
            begin
                char_next = CHAR_MINUS;
                last_next = 1'b0;
                sign_next = 1'b0;
            end
            else
            begin
                char_next = CHAR_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, cur_digit};
                last_next = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
        if (load_en)
        begin
            busy_next = 1'b1;
            sign_next = stg_neg[NUM_STAGES];
            idx_next  = top_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            sign_reg  <= 1'b0;
            idx_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            sign_reg  <= sign_next;
            idx_reg   <= idx_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        if (load_en)
        begin
            dig_reg <= stg_bcd[NUM_STAGES];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

    `ASSERT_IMPL(a_last_is_digit, clk, rst_n,
        m_tvalid && m_tlast |-> m_tdata != CHAR_MINUS, "last character is a sign")
    `ASSERT_IMPL(a_digit_range, clk, rst_n,
        busy_reg && !sign_reg |-> cur_digit <= DIGIT_MAX, "bcd digit out of range")
    `ASSERT_NEVER(a_load_overrun, clk, rst_n,
        load_en && busy_reg && !finishing, "serializer loaded while busy")
    `ASSERT_IMPL(a_sign_first, clk, rst_n,
        m_tvalid && m_tready && m_tdata == CHAR_MINUS |=>
        !(m_tvalid && m_tdata == CHAR_MINUS), "two sign characters in a row")

endmodule

// ===== hdl/sidc_dabble.sv =====
// ---------------------------------------------------------------------------
// sidc_dabble
// one pipeline stage of shift-and-add-3 binary to bcd conversion
// ---------------------------------------------------------------------------
module sidc_dabble
    import sidc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int DIGITS     = num_digits(VALUE_BITS_DEF),
    parameter int STEPS      = STAGE_STEPS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [DIGITS*DIGIT_BITS-1:0] in_bcd,
    input  logic [VALUE_BITS-1:0]        in_bin,
    input  logic                         in_neg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [DIGITS*DIGIT_BITS-1:0] out_bcd,
    output logic [VALUE_BITS-1:0]        out_bin,
    output logic                         out_neg
);

    localparam int BCD_BITS = DIGITS * DIGIT_BITS;
    localparam int W        = BCD_BITS + VALUE_BITS;

    logic                  valid_reg;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [VALUE_BITS-1:0] bin_reg;
    logic                  neg_reg;
    logic [W-1:0]          work;
    logic                  load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        work = {in_bcd, in_bin};
        for (int s = 0; s < STEPS; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (work[VALUE_BITS + d*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_ADJ_MIN)
                begin
                    work[VALUE_BITS + d*DIGIT_BITS +: DIGIT_BITS] =
                        work[VALUE_BITS + d*DIGIT_BITS +: DIGIT_BITS] + DIGIT_ADJ;
                end
            end
            work = {work[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= work[W-1:VALUE_BITS];
            bin_reg <= work[VALUE_BITS-1:0];
            neg_reg <= in_neg;
        end
    end

    assign out_valid = valid_reg;
    assign out_bcd   = bcd_reg;
    assign out_bin   = bin_reg;
    assign out_neg   = neg_reg;

endmodule

// ===== tb/sv/decimal_text_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// decimal_text_checker
// watches both stream channels of the integer to decimal text converter,
// works out the expected characters of every accepted word and compares
// each character word that leaves the block against the oldest expectation
// ---------------------------------------------------------------------------
module decimal_text_checker
    import sidc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_BITS-1:0]   s_tdata,   // [31:0] value
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [CHAR_BITS-1:0] m_tdata,   // [7:0] character
    input  logic                 m_tlast,
    output int                   error_count,
    output int                   pending_count
);

    localparam logic [VALUE_BITS-1:0] RADIX = 10;

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } text_char_t;

    text_char_t expected_text[$];

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // decimal text of one value, most significant character first
    function automatic void push_decimal_text(input logic [IN_BITS-1:0] word);
        logic [VALUE_BITS-1:0]  value;
        logic [VALUE_BITS-1:0]  magnitude;
        logic                   negative;
        logic [DIGIT_BITS-1:0]  digits[0:31];
        int                     count;
        text_char_t             entry;
        value     = VALUE_BITS'(word);
        negative  = value[VALUE_BITS-1];
        // unsigned magnitude so the most negative value needs no special case
        magnitude = negative ? (~value + 1'b1) : value;
        count     = 0;
        do
        begin
            digits[count] = DIGIT_BITS'(magnitude % RADIX);
            count++;
            magnitude = magnitude / RADIX;
        end
        while (magnitude != 0);
        if (negative)
        begin
            entry.character = CHAR_MINUS;
            entry.last      = 1'b0;
            expected_text.push_back(entry);
        end
        for (int k = count - 1; k >= 0; k--)
        begin
            entry.character = CHAR_ZERO + CHAR_BITS'(digits[k]);
            entry.last      = (k == 0);
            expected_text.push_back(entry);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t oldest;
        if (!rst_n)
        begin
            expected_text.delete();
            error_count    = 0;
            pending_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                push_decimal_text(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_text.size() == 0)
                    report_mismatch($sformatf("unexpected word char=%0d last=%0b",
                                              m_tdata, m_tlast));
                else
                begin
                    oldest = expected_text.pop_front();
                    if (m_tdata !== oldest.character)
                        report_mismatch($sformatf("char %0d, want %0d",
                                                  m_tdata, oldest.character));
                    if (m_tlast !== oldest.last)
                        report_mismatch($sformatf("last %0b, want %0b on char %0d",
                                                  m_tlast, oldest.last, oldest.character));
                end
            end
            pending_count <= expected_text.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// stimulus and verdict for the integer to decimal text converter
// ---------------------------------------------------------------------------
// directed words cover zero, single digits, powers of ten and their
// neighbors and both extremes, then random words mix the full 32-bit range
// with values of every digit count; both channels idle at random, the
// receiver holds off long enough to back the block up and the sender pauses
// once until all text has come out
// ---------------------------------------------------------------------------
module testbench;
    import sidc_pkg::*;

    localparam int RANDOM_WORDS = 250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 30;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_BITS-1:0]   s_tdata = '0;   // [31:0] value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CHAR_BITS-1:0] m_tdata;        // [7:0] character
    logic                 m_tlast;

    int                   error_count;
    int                   pending_count;
    int                   cycle_count = 0;
    bit                   hold_rx_req = 1'b0;

    signed_int_to_decimal_ascii uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    decimal_text_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_word(input logic [IN_BITS-1:0] value, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [IN_BITS-1:0] random_value();
        int unsigned magnitude;
        int unsigned pow10;
        int          digits;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom();
        pow10 = 1;
        digits = $urandom_range(1, 9);
        for (int k = 0; k < digits; k++)
            pow10 = pow10 * 10;
        if (r < 80)
        begin
            if ($urandom_range(0, 9) == 0)
                magnitude = $urandom_range(1000000000, 2147483647);
            else
                magnitude = $urandom_range(0, pow10 - 1);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000 + $urandom_range(0, 12);
                1: return 32'h7fff_ffff - $urandom_range(0, 12);
                default: magnitude = pow10 + $urandom_range(0, 2) - 1;
            endcase
        end
        return $urandom_range(0, 1) ? -magnitude : magnitude;
    endfunction

    // receiver: ready stretches, random ready, short and long holds
    initial
    begin
        int len;
        int r;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            r   = $urandom_range(0, 9);
            len = $urandom_range(5, 40);
            if (hold_rx_req)
            begin
                hold_rx_req = 1'b0;
                for (int i = 0; i < LONG_HOLD; i++)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            else if (r < 3)
            begin
                for (int i = 0; i < len; i++)
                begin
                    m_tready <= 1'b1;
                    @(posedge clk);
                end
            end
            else if (r < 8)
            begin
                for (int i = 0; i < len; i++)
                begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                    @(posedge clk);
                end
            end
            else
            begin
                len = (r == 8) ? $urandom_range(1, 4) : $urandom_range(20, 60);
                for (int i = 0; i < len; i++)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        logic [IN_BITS-1:0] directed[$];
        int                 gap;
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
                     32'd99, 32'd100, -32'sd101, 32'd999999999, 32'd1000000000,
                     -32'sd1000000000, 32'd1234567890, -32'sd123, 32'd7,
                     32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h7fff_fff8,
                     32'h5555_5555, 32'haaaa_aaaa, 32'hffff_fff6, 32'd2147483640};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[i])
            send_word(directed[i], (i < 12) ? 0 : pick_gap());

        // long receiver hold while words keep coming
        hold_rx_req = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_count != 0)
                    @(posedge clk);
            end
            gap = ((i / 30) % 3 == 0) ? 0 : pick_gap();
            send_word(random_value(), gap);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sidc_pkg.sv
hdl/sidc_dabble.sv
hdl/signed_int_to_decimal_ascii.sv
tb/sv/decimal_text_checker.sv
tb/sv/testbench.sv
